/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define STSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with a fixed delay given by dly.
`define STSA_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

/* src/stsa_pkg.sv */
// Types and constants for the signed timestamp adder/subtractor.
`timescale 1ns / 1ps

package stsa_pkg;

  localparam int SEC_W      = 32;
  localparam int TICK_W     = 16;
  // ticks plus headroom for sums and the wrap constant (up to 65536)
  localparam int TICK_EXT_W = TICK_W + 2;

  typedef struct packed {
    logic              mode;
    logic              a_negative;
    logic [SEC_W-1:0]  a_seconds;
    logic [TICK_W-1:0] a_ticks;
    logic              b_negative;
    logic [SEC_W-1:0]  b_seconds;
    logic [TICK_W-1:0] b_ticks;
  } in_item_t;

  typedef struct packed {
    logic              res_negative;
    logic [SEC_W-1:0]  res_seconds;
    logic [TICK_W-1:0] res_ticks;
    logic              bad_input;
  } out_item_t;

  // after range check and magnitude compare
  typedef struct packed {
    logic              bad;
    logic              same_sign;
    logic              a_larger;
    logic              a_neg;
    logic              b_neg;
    logic [SEC_W-1:0]  a_sec;
    logic [TICK_W-1:0] a_tick;
    logic [SEC_W-1:0]  b_sec;
    logic [TICK_W-1:0] b_tick;
  } s1_t;

  // after tick arithmetic
  typedef struct packed {
    logic              bad;
    logic              same_sign;
    logic              res_neg;
    logic              tick_cy;   // carry on add, borrow on subtract
    logic [SEC_W-1:0]  large_sec;
    logic [SEC_W-1:0]  small_sec;
    logic [TICK_W-1:0] res_tick;
  } s2_t;

endpackage

/* src/stsa_compare.sv */
// Stage 1: tick range check, effective sign and magnitude compare.
`timescale 1ns / 1ps

module stsa_compare #(
  parameter int TICKS_PER_SECOND = 2000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  stsa_pkg::in_item_t item_i,
  output logic              valid_o,
  output stsa_pkg::s1_t     stage_o
);

  localparam logic [stsa_pkg::TICK_EXT_W-1:0] TPS =
    stsa_pkg::TICK_EXT_W'(TICKS_PER_SECOND);

  logic          valid_r;
  stsa_pkg::s1_t stage_r, stage_nxt;
  logic          b_eff;

  always_comb begin
    b_eff = item_i.b_negative ^ item_i.mode;
    stage_nxt.bad = ({2'b00, item_i.a_ticks} >= TPS) || ({2'b00, item_i.b_ticks} >= TPS);
    stage_nxt.same_sign = (item_i.a_negative == b_eff);
    stage_nxt.a_larger  = (item_i.a_seconds > item_i.b_seconds) ||
                          ((item_i.a_seconds == item_i.b_seconds) &&
                           (item_i.a_ticks > item_i.b_ticks));
    stage_nxt.a_neg  = item_i.a_negative;
    stage_nxt.b_neg  = b_eff;
    stage_nxt.a_sec  = item_i.a_seconds;
    stage_nxt.a_tick = item_i.a_ticks;
    stage_nxt.b_sec  = item_i.b_seconds;
    stage_nxt.b_tick = item_i.b_ticks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

/* src/stsa_ticks.sv */
// Stage 2: operand ordering and tick add/subtract with carry or borrow.
`timescale 1ns / 1ps

module stsa_ticks #(
  parameter int TICKS_PER_SECOND = 2000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  stsa_pkg::s1_t stage_i,
  output logic          valid_o,
  output stsa_pkg::s2_t stage_o
);

  localparam int EW = stsa_pkg::TICK_EXT_W;
  localparam logic [EW-1:0] TPS = EW'(TICKS_PER_SECOND);

  logic          valid_r;
  stsa_pkg::s2_t stage_r, stage_nxt;
  logic [EW-1:0] lt, st, sum, diff;

  always_comb begin
    lt = stage_i.a_larger ? {2'b00, stage_i.a_tick} : {2'b00, stage_i.b_tick};
    st = stage_i.a_larger ? {2'b00, stage_i.b_tick} : {2'b00, stage_i.a_tick};
    sum  = lt + st;
    diff = lt - st;

    stage_nxt.bad       = stage_i.bad;
    stage_nxt.same_sign = stage_i.same_sign;
    stage_nxt.large_sec = stage_i.a_larger ? stage_i.a_sec : stage_i.b_sec;
    stage_nxt.small_sec = stage_i.a_larger ? stage_i.b_sec : stage_i.a_sec;

    if (stage_i.same_sign) begin
      stage_nxt.res_neg  = stage_i.a_neg;
      stage_nxt.tick_cy  = (sum >= TPS);
      stage_nxt.res_tick = stage_nxt.tick_cy ? stsa_pkg::TICK_W'(sum - TPS)
                                             : stsa_pkg::TICK_W'(sum);
    end else begin
      stage_nxt.res_neg  = stage_i.a_larger ? stage_i.a_neg : stage_i.b_neg;
      stage_nxt.tick_cy  = (lt < st);
      // on borrow, diff wraps; adding the tick limit brings it back in range
      stage_nxt.res_tick = stage_nxt.tick_cy ? stsa_pkg::TICK_W'(diff + TPS)
                                             : stsa_pkg::TICK_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

/* src/stsa_seconds.sv */
// Stage 3: seconds add/subtract, zero sign fix and bad-input override.
`timescale 1ns / 1ps

module stsa_seconds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  stsa_pkg::s2_t       stage_i,
  output logic                valid_o,
  output stsa_pkg::out_item_t item_o
);

  logic                        valid_r;
  stsa_pkg::out_item_t         item_r, item_nxt;
  logic [stsa_pkg::SEC_W-1:0]  sec;

  always_comb begin
    if (stage_i.same_sign) begin
      sec = stage_i.large_sec + stage_i.small_sec +
            {{(stsa_pkg::SEC_W-1){1'b0}}, stage_i.tick_cy};
    end else begin
      sec = stage_i.large_sec - stage_i.small_sec -
            {{(stsa_pkg::SEC_W-1){1'b0}}, stage_i.tick_cy};
    end

    if (stage_i.bad) begin
      item_nxt.res_negative = 1'b0;
      item_nxt.res_seconds  = '0;
      item_nxt.res_ticks    = '0;
      item_nxt.bad_input    = 1'b1;
    end else begin
      // zero is always reported positive
      item_nxt.res_negative = stage_i.res_neg && ((sec != '0) || (stage_i.res_tick != '0));
      item_nxt.res_seconds  = sec;
      item_nxt.res_ticks    = stage_i.res_tick;
      item_nxt.bad_input    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

/* src/signed_timestamp_add_sub.sv */
// Top level: three-stage signed timestamp adder/subtractor.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  input    | start / busy       | in_data  (in_item_t)
//  result   | out_valid (strobe) | out_data (out_item_t)
//
// The pipeline takes one item per cycle through its stages, in order:
// range check and compare, tick arithmetic, seconds arithmetic, each one
// register stage. busy is high only while rst_n is low; a synchronous reset
// clears the stage valid bits. The result is shown for one cycle and the
// pipeline never stalls.
`timescale 1ns / 1ps

module signed_timestamp_add_sub #(
  parameter int TICKS_PER_SECOND = 2000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  stsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  output stsa_pkg::out_item_t out_data
);

  logic          v1, v2;
  stsa_pkg::s1_t s1;
  stsa_pkg::s2_t s2;

  assign busy = ~rst_n;

  stsa_compare #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_compare (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(start && !busy),
    .item_i (in_data),
    .valid_o(v1),
    .stage_o(s1)
  );

  stsa_ticks #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_ticks (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(v1),
    .stage_i(s1),
    .valid_o(v2),
    .stage_o(s2)
  );

  stsa_seconds u_seconds (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(v2),
    .stage_i(s2),
    .valid_o(out_valid),
    .item_o (out_data)
  );

endmodule

/* src/stsa_checker.sv */
// Port-level checker for the timestamp adder/subtractor, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stsa_checker #(
  parameter int TICKS_PER_SECOND = 2000
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input stsa_pkg::in_item_t  in_data,
  input logic                out_valid,
  input stsa_pkg::out_item_t out_data
);

  localparam logic [stsa_pkg::TICK_EXT_W-1:0] TPS =
    stsa_pkg::TICK_EXT_W'(TICKS_PER_SECOND);

  logic acc;
  logic tick_bad;
  logic bad_out;
  logic res_zero;
  logic tick_ok;

  assign acc      = start && !busy;
  assign tick_bad = ({2'b00, in_data.a_ticks} >= TPS) || ({2'b00, in_data.b_ticks} >= TPS);
  assign bad_out  = out_valid && out_data.bad_input;
  assign res_zero = (out_data.res_seconds == '0) && (out_data.res_ticks == '0);
  assign tick_ok  = ({2'b00, out_data.res_ticks} < TPS);

  `STSA_ASSERT_DLY(a_result_follows, clk, rst_n, acc, 3, out_valid)
  `STSA_ASSERT_DLY(a_bad_flagged, clk, rst_n, acc && tick_bad, 3, out_data.bad_input)
  `STSA_ASSERT_IMP(a_bad_zero, clk, rst_n, bad_out, !out_data.res_negative && res_zero)
  `STSA_ASSERT_IMP(a_zero_pos, clk, rst_n, out_valid && res_zero, !out_data.res_negative)
  `STSA_ASSERT_IMP(a_ticks_range, clk, rst_n, out_valid, tick_ok)

endmodule

bind signed_timestamp_add_sub stsa_checker #(
  .TICKS_PER_SECOND(TICKS_PER_SECOND)
) u_stsa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);

/* test/tb_top.sv */
// Testbench for signed_timestamp_add_sub: directed and random operand pairs vs. a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TICK_LIMIT = 2000;
  localparam int IDLE_LIMIT   = 500;
  localparam int RANDOM_ITEMS = 1950;
  localparam int BLOCK_LEN    = 50;
  localparam int TAIL_CYCLES  = 12;

  class tstamp_scoreboard;
    stsa_pkg::out_item_t expected_sums[$];
    int unsigned operands_seen = 0;
    int unsigned sums_checked  = 0;
    int unsigned bad_seen      = 0;
    int unsigned zero_seen     = 0;
    int unsigned neg_seen      = 0;
    int unsigned fail_count    = 0;

    function stsa_pkg::out_item_t expected_sum(stsa_pkg::in_item_t op);
      stsa_pkg::out_item_t        r;
      logic                       b_neg;
      logic                       a_larger;
      logic [stsa_pkg::SEC_W-1:0] lg_sec;
      logic [stsa_pkg::SEC_W-1:0] sm_sec;
      logic [stsa_pkg::SEC_W-1:0] sec;
      int unsigned                lg_tick;
      int unsigned                sm_tick;
      int unsigned                tick;
      r = '0;
      if (op.a_ticks >= TICK_LIMIT || op.b_ticks >= TICK_LIMIT) begin
        r.bad_input = 1'b1;
        return r;
      end
      // subtraction flips the sign of b
      b_neg = op.b_negative ^ op.mode;
      if (op.a_negative == b_neg) begin
        tick = op.a_ticks + op.b_ticks;
        sec  = op.a_seconds + op.b_seconds;
        if (tick >= TICK_LIMIT) begin
          tick = tick - TICK_LIMIT;
          sec  = sec + 1;
        end
        r.res_negative = op.a_negative;
      end else begin
        a_larger = (op.a_seconds > op.b_seconds) ||
                   (op.a_seconds == op.b_seconds && op.a_ticks > op.b_ticks);
        lg_sec  = a_larger ? op.a_seconds : op.b_seconds;
        lg_tick = a_larger ? op.a_ticks : op.b_ticks;
        sm_sec  = a_larger ? op.b_seconds : op.a_seconds;
        sm_tick = a_larger ? op.b_ticks : op.a_ticks;
        sec = lg_sec - sm_sec;
        if (lg_tick < sm_tick) begin
          tick = lg_tick + TICK_LIMIT - sm_tick;
          sec  = sec - 1;
        end else begin
          tick = lg_tick - sm_tick;
        end
        r.res_negative = a_larger ? op.a_negative : b_neg;
      end
      r.res_seconds = sec;
      r.res_ticks   = stsa_pkg::TICK_W'(tick);
      if (sec == 0 && tick == 0) r.res_negative = 1'b0;
      return r;
    endfunction

    function void flag(string msg);
      fail_count++;
      $error("%s", msg);
    endfunction

    function void note_operands(stsa_pkg::in_item_t op);
      stsa_pkg::out_item_t want;
      want = expected_sum(op);
      operands_seen++;
      if (want.bad_input) bad_seen++;
      else if (want.res_seconds == 0 && want.res_ticks == 0) zero_seen++;
      if (want.res_negative) neg_seen++;
      expected_sums.push_back(want);
    endfunction

    function void check_result(stsa_pkg::out_item_t got);
      stsa_pkg::out_item_t want;
      if (expected_sums.size() == 0) begin
        flag($sformatf("result with no item pending: %h", got));
        return;
      end
      want = expected_sums.pop_front();
      sums_checked++;
      if (got.res_negative !== want.res_negative)
        flag($sformatf("res_negative: expected %0d, got %0d",
                       want.res_negative, got.res_negative));
      if (got.res_seconds !== want.res_seconds)
        flag($sformatf("res_seconds: expected %0d, got %0d",
                       want.res_seconds, got.res_seconds));
      if (got.res_ticks !== want.res_ticks)
        flag($sformatf("res_ticks: expected %0d, got %0d",
                       want.res_ticks, got.res_ticks));
      if (got.bad_input !== want.bad_input)
        flag($sformatf("bad_input: expected %0d, got %0d",
                       want.bad_input, got.bad_input));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  stsa_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  stsa_pkg::out_item_t out_data;
  int                  idle_run = 0;

  tstamp_scoreboard sb;

  signed_timestamp_add_sub #(
    .TICKS_PER_SECOND(TICK_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_operands(in_data);
    end
    if ((start && !busy) || out_valid) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= IDLE_LIMIT) begin
      $display("signed_timestamp_add_sub verification failed");
      $finish;
    end
  end

  task automatic send_operands(stsa_pkg::in_item_t op);
    start   <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every pending sum has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
  endtask

  function automatic int gap_len(bit streaming);
    int pick;
    if (streaming) return 0;
    pick = $urandom_range(0, 19);
    if (pick < 14) return 0;
    if (pick < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stsa_pkg::in_item_t make_op(
      logic mode, logic an, logic [stsa_pkg::SEC_W-1:0] as,
      logic [stsa_pkg::TICK_W-1:0] at, logic bn,
      logic [stsa_pkg::SEC_W-1:0] bs, logic [stsa_pkg::TICK_W-1:0] bt);
    stsa_pkg::in_item_t op;
    op.mode       = mode;
    op.a_negative = an;
    op.a_seconds  = as;
    op.a_ticks    = at;
    op.b_negative = bn;
    op.b_seconds  = bs;
    op.b_ticks    = bt;
    return op;
  endfunction

  function automatic logic [stsa_pkg::SEC_W-1:0] rand_seconds();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       return $urandom_range(0, 5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [stsa_pkg::TICK_W-1:0] rand_ticks();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return stsa_pkg::TICK_W'(TICK_LIMIT - 1);
      2:       return $urandom_range(TICK_LIMIT, 16'hFFFF);   // out of range
      default: return $urandom_range(0, TICK_LIMIT - 1);
    endcase
  endfunction

  function automatic stsa_pkg::in_item_t random_op();
    stsa_pkg::in_item_t op;
    op = make_op($urandom_range(0, 1), $urandom_range(0, 1), rand_seconds(), rand_ticks(),
                 $urandom_range(0, 1), rand_seconds(), rand_ticks());
    // equal magnitudes drive the compare and zero paths
    if ($urandom_range(0, 3) == 0) op.b_seconds = op.a_seconds;
    if ($urandom_range(0, 5) == 0) op.b_ticks = op.a_ticks;
    return op;
  endfunction

  initial begin
    stsa_pkg::in_item_t          directed[$];
    logic [stsa_pkg::SEC_W-1:0]  max_s;
    logic [stsa_pkg::TICK_W-1:0] top_t;
    bit                          streaming;
    sb    = new();
    max_s = 32'hFFFF_FFFF;
    top_t = stsa_pkg::TICK_W'(TICK_LIMIT - 1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(make_op(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_op(0, 0, max_s, top_t, 0, max_s, top_t));
    directed.push_back(make_op(0, 0, max_s, top_t, 0, 0, 1));      // wraps to zero
    directed.push_back(make_op(0, 1, max_s, top_t, 1, 0, 1));      // negative wrap to zero
    directed.push_back(make_op(0, 1, 5, 100, 0, 5, 100));          // cancels out
    directed.push_back(make_op(1, 1, 7, 3, 1, 7, 3));
    directed.push_back(make_op(1, 0, 10, 5, 0, 3, top_t));         // tick borrow
    directed.push_back(make_op(1, 0, 3, 0, 0, 10, 0));
    directed.push_back(make_op(0, 1, 20, 1500, 1, 30, 800));
    directed.push_back(make_op(1, 0, 4, 10, 1, 6, 1990));
    directed.push_back(make_op(0, 0, 9, 50, 1, 9, 60));            // ticks decide the compare
    directed.push_back(make_op(0, 1, 9, 60, 0, 9, 50));
    directed.push_back(make_op(1, 1, 0, 0, 0, 0, 1));
    directed.push_back(make_op(0, 0, 0, stsa_pkg::TICK_W'(TICK_LIMIT), 0, 0, 0));
    directed.push_back(make_op(0, 0, 0, 0, 1, 0, 16'hFFFF));
    directed.push_back(make_op(1, 1, max_s, 16'hFFFF, 1, max_s, 16'hFFFF));
    directed.push_back(make_op(0, 0, max_s, top_t, 1, 0, 0));
    directed.push_back(make_op(1, 0, 0, 0, 0, max_s, top_t));
    directed.push_back(make_op(0, 1, max_s, 0, 0, 0, 1));
    directed.push_back(make_op(1, 0, 1, 0, 0, 0, 1));
    foreach (directed[i]) send_operands(directed[i]);
    drain();

    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_LEN; blk++) begin
      streaming = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < BLOCK_LEN; k++) begin
        send_operands(random_op());
        pause(gap_len(streaming));
      end
      if (blk == 10 || $urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d operand pairs, checked %0d sums.", sb.operands_seen, sb.sums_checked);
    $display("Seen: %0d out-of-range ticks, %0d zero sums, %0d negative sums.",
             sb.bad_seen, sb.zero_seen, sb.neg_seen);
    if (sb.fail_count == 0) begin
      $display("signed_timestamp_add_sub verification clean");
    end else begin
      $display("signed_timestamp_add_sub verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/stsa_pkg.sv
src/stsa_compare.sv
src/stsa_ticks.sv
src/stsa_seconds.sv
src/signed_timestamp_add_sub.sv
src/stsa_checker.sv
test/tb_top.sv
